### src/dmmm_pkg.sv
// Shared types and constants for the grade statistics block.
`timescale 1ns / 1ps
package dmmm_pkg;

  localparam int GRADE_W = 14;
  localparam int COUNT_W = 9;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_RD_A,
    ST_SORT_RD_B,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN,
    ST_MED_RD,
    ST_MED,
    ST_OUT
  } state_t;

endpackage

### src/dmmm_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module dmmm_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### src/dmmm_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dmmm_div #(
  parameter int NW = 26,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [DW:0]   rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW-1:0] dreg;

  assign trial = {rem[DW-1:0], quo[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        rem  <= '0;
        quo  <= num;
        dreg <= den;
      end else if (busy) begin
        if (trial >= {1'b0, dreg}) begin
          rem <= trial - {1'b0, dreg};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### src/dataset_mean_median_mode_top.sv
// Top level: grade store, sort, mean/median/mode engine.
//
//  channel | direction | valid     | stall     | word
//  grades  | in        | in_valid  | in_stall  | grade, last
//  result  | out       | out_valid | out_stall | mean/median/mode, count, flag
//
// Grades load into the store at one word per cycle. After the last word the
// store is bubble-sorted in place through its single RAM port: a compare reads
// both words and a swap writes them back in two phases. The mean divider
// (1 bit/cycle) runs alongside the mode scan; the median then reads the two
// middle entries and the result waits for the mean.
// in_stall stays high from the last word until the result is taken.
// Reset is synchronous; the store itself is never cleared.
`timescale 1ns / 1ps
module dataset_mean_median_mode_top #(
  parameter int MAX_ITEMS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dmmm_pkg::GRADE_W-1:0]   grade,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dmmm_pkg::GRADE_W-1:0]   mean_value,
  output logic [dmmm_pkg::GRADE_W-1:0]   median_value,
  output logic [dmmm_pkg::GRADE_W-1:0]   mode_value,
  output logic [dmmm_pkg::COUNT_W-1:0]   item_count,
  output logic                           overflowed
);
  import dmmm_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int NW = $clog2(MAX_ITEMS + 1);   // count width
  localparam int TW = GRADE_W + NW;            // total width

  state_t state, state_next;
  logic [NW-1:0] count;
  logic [TW-1:0] total;
  logic          ovf;

  // sort bookkeeping: pass limit and inner index
  logic [NW-1:0] lim, idx;
  logic          swapped;
  logic [GRADE_W-1:0] va, vb;
  logic          wr_phase;  // 0 writes b at idx, 1 writes a at idx+1

  // mode scan
  logic [GRADE_W-1:0] cur_val, best_val;
  logic [NW-1:0]      run, best_run;

  // median and mean hand-off
  logic mean_ready;
  logic [GRADE_W-1:0] med_lo;
  logic [GRADE_W:0]   med_sum;
  logic               med_phase;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [GRADE_W-1:0] ram_wdata, ram_rdata;

  dmmm_ram #(.WIDTH(GRADE_W), .DEPTH(MAX_ITEMS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic          div_start, div_done;
  logic [TW-1:0] div_q;

  dmmm_div #(.NW(TW), .DW(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(total), .den(count),
    .done(div_done), .quo(div_q)
  );

  logic in_acc, store_ok;
  assign in_acc   = in_valid && !in_stall;
  assign store_ok = count < NW'(MAX_ITEMS);
  assign in_stall = (state != ST_LOAD);

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx[AW-1:0];
    ram_wdata = vb;
    unique case (state)
      ST_LOAD: begin
        ram_we    = in_acc && store_ok;
        ram_addr  = count[AW-1:0];
        ram_wdata = grade;
      end
      ST_SORT_RD_B: ram_addr = AW'(idx + 1'b1);
      ST_SORT_WR: begin
        ram_we    = 1'b1;
        ram_addr  = wr_phase ? AW'(idx + 1'b1) : idx[AW-1:0];
        ram_wdata = wr_phase ? va : vb;
      end
      ST_SCAN:   ram_addr = AW'(idx + 1'b1);
      ST_MED_RD: ram_addr = AW'((count >> 1) - 1'b1);
      ST_MED:    ram_addr = AW'(count >> 1);
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_LOAD:
        if (in_acc && last) state_next = (count == '0 && !store_ok) ? ST_OUT :
                                        ST_SORT_RD_A;
      ST_SORT_RD_A: begin
        if (lim <= NW'(1)) state_next = ST_DIV;
        else if (NW'(idx + 1'b1) >= lim) state_next = swapped ? ST_SORT_RD_A : ST_DIV;
        else state_next = ST_SORT_RD_B;
      end
      ST_SORT_RD_B: state_next = ST_SORT_CMP;
      ST_SORT_CMP:  state_next = (va > ram_rdata) ? ST_SORT_WR : ST_SORT_RD_A;
      ST_SORT_WR:   if (wr_phase) state_next = ST_SORT_RD_A;
      ST_DIV: begin
        div_start  = 1'b1;
        state_next = ST_SCAN_RD;
      end
      ST_SCAN_RD: state_next = ST_SCAN;
      ST_SCAN:    if (idx == count) state_next = ST_MED_RD;
      ST_MED_RD:  state_next = ST_MED;
      ST_MED:     if (med_phase && (div_done || mean_ready)) state_next = ST_OUT;
      ST_OUT:     if (!out_stall) state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  assign med_sum = {1'b0, med_lo} + {1'b0, ram_rdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      total      <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
      mean_ready <= 1'b0;
    end else begin
      state <= state_next;
      if (div_done) begin
        mean_value <= div_q[GRADE_W-1:0];
        mean_ready <= 1'b1;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (store_ok) begin
              count <= count + 1'b1;
              total <= total + TW'(grade);
            end else begin
              ovf <= 1'b1;
            end
            if (last) begin
              lim        <= store_ok ? NW'(count + 1'b1) : count;
              idx        <= '0;
              swapped    <= 1'b0;
              mean_ready <= 1'b0;
              mean_value <= '0;
              median_value <= '0;
              mode_value <= '0;
              if (count == '0 && !store_ok) out_valid <= 1'b1;
            end
          end
        end
        ST_SORT_RD_A: begin
          wr_phase <= 1'b0;
          if (NW'(idx + 1'b1) >= lim) begin
            // end of a pass
            idx     <= '0;
            swapped <= 1'b0;
            lim     <= swapped ? NW'(lim - 1'b1) : NW'(1);
          end
        end
        ST_SORT_RD_B: va <= ram_rdata;
        ST_SORT_CMP: begin
          vb <= ram_rdata;
          if (va > ram_rdata) swapped <= 1'b1;
          else idx <= idx + 1'b1;
        end
        ST_SORT_WR: begin
          wr_phase <= 1'b1;
          if (wr_phase) idx <= idx + 1'b1;
        end
        ST_DIV: begin
          idx      <= '0;
          run      <= '0;
          best_run <= '0;
          best_val <= '0;
        end
        ST_SCAN_RD: idx <= idx;
        ST_SCAN: begin
          if (idx != count) begin
            if (run != '0 && ram_rdata == cur_val) begin
              run <= run + 1'b1;
              if (NW'(run + 1'b1) > best_run) begin
                best_run <= NW'(run + 1'b1);
                best_val <= cur_val;
              end
            end else begin
              run     <= NW'(1);
              cur_val <= ram_rdata;
              if (best_run == '0) begin
                best_run <= NW'(1);
                best_val <= ram_rdata;
              end
            end
            idx <= idx + 1'b1;
          end
        end
        ST_MED_RD: med_phase <= 1'b0;
        ST_MED: begin
          if (!med_phase) begin
            med_lo    <= ram_rdata;
            med_phase <= 1'b1;
          end
          if (med_phase && (div_done || mean_ready)) begin
            median_value <= count[0] ? ram_rdata : med_sum[GRADE_W:1];
            mode_value   <= best_val;
            out_valid    <= 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            count     <= '0;
            total     <= '0;
            ovf       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // The scan reads one entry ahead of idx, so the word in ram_rdata matches idx.
  assign item_count = COUNT_W'(count);
  assign overflowed = ovf;

endmodule
